/* rtl/sitr_pkg.sv */
// Package for the signed integer to radix text block.
// Holds the radix limits, character codes, the divider status type and the
// digit-to-character mapping. No dependencies.
`default_nettype none

package sitr_pkg;

    // Radix register limits and reset value.
    localparam logic [5:0] RADIX_MIN   = 6'd2;
    localparam logic [5:0] RADIX_MAX   = 6'd36;
    localparam logic [5:0] RADIX_RESET = 6'd10;

    // Largest digit value that has a character.
    localparam logic [5:0] DIGIT_MAX = 6'd35;

    // Dividend bits consumed by the divider in one cycle.
    localparam int STEP_BITS = 8;

    // ASCII codes used by the character mapping.
    localparam logic [7:0] CHAR_MINUS = 8'h2d;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;

    // Status of the digit divider as seen by the controller.
    typedef struct packed {
        logic       busy;
        logic       done;
        logic       quo_zero;
        logic [5:0] rem;
    } div_status_t;

    // Maps a digit value to its character: 0-9 then lower-case a-z.
    function automatic logic [7:0] digit_char(input logic [5:0] digit);
        logic [5:0] d;
        logic [7:0] ch;
        d = (digit > DIGIT_MAX) ? DIGIT_MAX : digit;
        if (d < 6'd10)
        begin
            ch = CHAR_ZERO + {2'b00, d};
        end
        else
        begin
            ch = CHAR_LOWER_A + {2'b00, d} - 8'd10;
        end
        return ch;
    endfunction

endpackage

`default_nettype wire

/* rtl/sitr_ram.sv */
// Generic single-write, single-read synchronous RAM with a registered read.
// Used for the digit store of the radix text block. No dependencies.
`default_nettype none

module sitr_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 33
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic                                   re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* rtl/sitr_divider.sv */
// Digit divider: divides the working magnitude by the radix, eight dividend
// bits per cycle, leaving the quotient in place and the remainder as the digit.
// Depends on sitr_pkg.
`default_nettype none

module sitr_divider
    import sitr_pkg::*;
#(
    parameter int VALUE_BITS = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [5:0]            radix,
    input  wire logic                  start_load,
    input  wire logic                  start_next,
    input  wire logic [VALUE_BITS-1:0] mag,
    output div_status_t                status
);

    localparam int CHUNKS   = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
    localparam int PAD_BITS = CHUNKS * STEP_BITS;
    localparam int CNT_W    = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;

    logic [PAD_BITS-1:0] work_reg, work_next;
    logic [5:0]          rem_reg, rem_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic                nz_reg, nz_next;

    // Chunk step results.
    logic [PAD_BITS-1:0] step_work;
    logic [5:0]          step_rem;
    logic                step_nz;
    logic [6:0]          trial;

    // Eight restoring division steps on the top bits of the working word.
    // Quotient bits shift in at the bottom, so after all chunks the word
    // holds the quotient.
    always_comb
    begin
        step_work = work_reg;
        step_rem  = rem_reg;
        step_nz   = nz_reg;
        trial     = '0;
        for (int i = 0; i < STEP_BITS; i++)
        begin
            trial     = {step_rem, step_work[PAD_BITS-1]};
            step_work = {step_work[PAD_BITS-2:0], 1'b0};
            if (trial >= {1'b0, radix})
            begin
                step_rem     = 6'(trial - {1'b0, radix});
                step_work[0] = 1'b1;
                step_nz      = 1'b1;
            end
            else
            begin
                step_rem = trial[5:0];
            end
        end
    end

    // Control of one division pass.
    always_comb
    begin
        work_next = work_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        nz_next   = nz_reg;
        if (start_load || start_next)
        begin
            if (start_load)
            begin
                work_next = PAD_BITS'(mag);
            end
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
            done_next = 1'b0;
            nz_next   = 1'b0;
        end
        else if (busy_reg)
        begin
            work_next = step_work;
            rem_next  = step_rem;
            nz_next   = step_nz;
            cnt_next  = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(CHUNKS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        rem_reg  <= rem_next;
        nz_reg   <= nz_next;
    end

    assign status.busy     = busy_reg;
    assign status.done     = done_reg;
    assign status.quo_zero = !nz_reg;
    assign status.rem      = rem_reg;

endmodule

`default_nettype wire

/* rtl/signed_integer_to_radix_text.sv */
// Signed integer to radix text converter, top level.
// Depends on sitr_pkg, sitr_divider and sitr_ram.
//
// Converts each signed value to its text in the configured radix (2 to 36),
// one ASCII character per output beat, most significant character first,
// with last set on the final character. Negative values start with '-' and
// zero gives "0". Digits are found least significant first by a divider that
// consumes eight bits per cycle and are kept in a small digit RAM. They are
// then read back in reverse, each character fetched from the RAM and then
// loaded into the output register, after the sign if there is one. One value
// is converted at a time; the next value is taken as soon as the last character
// has been placed in the output register. Radix writes of values outside 2 to
// 36 are ignored; the radix resets to 10.
`default_nettype none

module signed_integer_to_radix_text
    import sitr_pkg::*;
#(
    parameter int VALUE_BITS = 32
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         radix_wr_en,
    input  wire logic [5:0]                   radix_wr_data,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic signed [VALUE_BITS-1:0] value,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic [7:0]                        character,
    output logic                              last
);

    localparam int DIGIT_SLOTS = VALUE_BITS + 1;
    localparam int ADDR_W      = $clog2(DIGIT_SLOTS);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIV   = 3'd1;
    localparam logic [2:0] S_SIGN  = 3'd2;
    localparam logic [2:0] S_FETCH = 3'd3;
    localparam logic [2:0] S_LOAD  = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [5:0]        radix_reg;
    logic              neg_reg, neg_next;
    logic [ADDR_W-1:0] nd_reg, nd_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        char_reg, char_next;
    logic              last_reg, last_next;

    logic [VALUE_BITS-1:0] value_u;
    logic [VALUE_BITS-1:0] mag;
    logic                  in_accept;
    logic                  out_free;
    logic                  out_load;
    logic                  start_load;
    logic                  start_next;
    logic                  ram_we;
    logic                  ram_re;
    logic [5:0]            ram_rdata;
    div_status_t           div_status;

    // Radix register: out-of-range writes leave it unchanged.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= RADIX_RESET;
        end
        else if (radix_wr_en && radix_wr_data >= RADIX_MIN && radix_wr_data <= RADIX_MAX)
        begin
            radix_reg <= radix_wr_data;
        end
    end

    // Magnitude of the incoming value; the most negative value wraps to its
    // exact unsigned magnitude.
    assign value_u = value;
    assign mag     = value_u[VALUE_BITS-1] ? (~value_u + VALUE_BITS'(1)) : value_u;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    sitr_divider #(
        .VALUE_BITS (VALUE_BITS)
    ) u_divider (
        .clk        (clk),
        .rst_n      (rst_n),
        .radix      (radix_reg),
        .start_load (start_load),
        .start_next (start_next),
        .mag        (mag),
        .status     (div_status)
    );

    sitr_ram #(
        .WIDTH (6),
        .DEPTH (DIGIT_SLOTS)
    ) u_digit_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (nd_reg),
        .wdata (div_status.rem),
        .re    (ram_re),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    // Sequencer: divide into the digit RAM, then read it back in reverse.
    always_comb
    begin
        state_next = state_reg;
        neg_next   = neg_reg;
        nd_next    = nd_reg;
        idx_next   = idx_reg;
        char_next  = char_reg;
        last_next  = last_reg;
        out_load   = 1'b0;
        start_load = 1'b0;
        start_next = 1'b0;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    start_load = 1'b1;
                    neg_next   = value_u[VALUE_BITS-1];
                    nd_next    = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_status.done)
                begin
                    ram_we = 1'b1;
                    if (div_status.quo_zero)
                    begin
                        idx_next   = nd_reg;
                        state_next = neg_reg ? S_SIGN : S_FETCH;
                    end
                    else
                    begin
                        nd_next    = nd_reg + ADDR_W'(1);
                        start_next = 1'b1;
                    end
                end
            end
            S_SIGN:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    char_next  = CHAR_MINUS;
                    last_next  = 1'b0;
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                ram_re     = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (out_free)
                begin
                    out_load  = 1'b1;
                    char_next = digit_char(ram_rdata);
                    last_next = (idx_reg == '0);
                    if (idx_reg == '0)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg - ADDR_W'(1);
                        state_next = S_FETCH;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register valid flag.
    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload and counters.
    always_ff @(posedge clk)
    begin
        neg_reg  <= neg_next;
        nd_reg   <= nd_next;
        idx_reg  <= idx_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign character = char_reg;
    assign last      = last_reg;

    // The radix register never holds a base outside its range.
    assert property (@(posedge clk) disable iff (!rst_n)
        radix_reg >= RADIX_MIN && radix_reg <= RADIX_MAX)
        else $error("radix register out of range");

    // Digits are written only when a division pass has finished.
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_DIV && !div_status.busy))
        else $error("digit write while divider busy");

    // Loading the final character returns the sequencer to idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && last_next) |=> (state_reg == S_IDLE))
        else $error("sequencer not idle after final character");

    // The digit count stays within the store while dividing.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (nd_reg < ADDR_W'(VALUE_BITS)))
        else $error("digit count overflow");

endmodule

`default_nettype wire
